// File: rtl/core/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache.
`timescale 1ns / 1ps
`default_nettype none
package lkv_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MATCH  = 4'b0010,
    S_GATHER = 4'b0100,
    S_APPLY  = 4'b1000
  } state_e;

  // Request broadcast to every cell.
  typedef struct packed {
    logic              put;
    logic              hit;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } cmd_t;

  // Data rippled from cell to cell.
  typedef struct packed {
    logic              hit;
    logic              first_free;
    logic [DATA_W-1:0] value;
  } chain_t;

endpackage
`default_nettype wire

// File: rtl/core/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache.
// A request runs through these steps in order: accept, match in every cell, gather the
// hit along the cell row, then apply the recency and eviction update in all cells at
// once; a get also waits in the apply step while the output register still holds an
// untaken result. Puts produce no response. Misses return all ones with hit low. Capacity
// above ENTRIES saturates to ENTRIES; capacity zero empties the cache on the next put.
`timescale 1ns / 1ps
`default_nettype none
module lru_key_value_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire  [lkv_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire                        action_i,
  input  wire  [lkv_pkg::DATA_W-1:0] lookup_key_i,
  input  wire  [lkv_pkg::DATA_W-1:0] store_value_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic                       hit_o,
  output logic [lkv_pkg::DATA_W-1:0] read_value_o
);
  import lkv_pkg::*;

  localparam int unsigned RKW = $clog2(ENTRIES + 1);
  localparam int unsigned CW  = (RKW > CAP_W) ? RKW : CAP_W;

  state_e            state_q, state_d;
  logic [CAP_W-1:0]  cap_q;
  logic              req_put_q;
  logic [DATA_W-1:0] req_key_q, req_val_q;
  logic              hit_q;
  logic [RKW-1:0]    old_rank_q;
  logic [DATA_W-1:0] hit_val_q;
  logic              out_valid_q, out_valid_d;
  logic              out_hit_q;
  logic [DATA_W-1:0] out_val_q;

  logic [CW-1:0]     cap_w;
  logic [RKW-1:0]    cap_eff;
  logic              out_free, apply_en, accept;
  cmd_t              cmd;
  chain_t            chain   [ENTRIES+1];
  logic [RKW-1:0]    rchain  [ENTRIES+1];

  assign cap_w   = CW'(cap_q);
  assign cap_eff = (cap_w > CW'(ENTRIES)) ? RKW'(ENTRIES) : RKW'(cap_w);

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign apply_en   = (state_q == S_APPLY) && (req_put_q || out_free);

  assign cmd.put   = req_put_q;
  assign cmd.hit   = hit_q;
  assign cmd.key   = req_key_q;
  assign cmd.value = req_val_q;

  assign chain[0].hit        = 1'b0;
  assign chain[0].first_free = 1'b1;
  assign chain[0].value      = '0;
  assign rchain[0]           = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkv_cell #(
      .RKW(RKW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .match_en_i  (state_q == S_MATCH),
      .apply_en_i  (apply_en),
      .cmd_i       (cmd),
      .old_rank_i  (old_rank_q),
      .cap_i       (cap_eff),
      .chain_i     (chain[g]),
      .chain_o     (chain[g+1]),
      .rank_chain_i(rchain[g]),
      .rank_chain_o(rchain[g+1])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_MATCH;
      S_MATCH:  state_d = S_GATHER;
      S_GATHER: state_d = S_APPLY;
      S_APPLY:  if (apply_en) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (apply_en && !req_put_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_put_q <= action_i;
      req_key_q <= lookup_key_i;
      req_val_q <= store_value_i;
    end
    if (state_q == S_GATHER) begin
      hit_q      <= chain[ENTRIES].hit;
      old_rank_q <= rchain[ENTRIES];
      hit_val_q  <= chain[ENTRIES].value;
    end
    if (apply_en && !req_put_q) begin
      out_hit_q <= hit_q;
      out_val_q <= hit_q ? hit_val_q : MISS_VALUE;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign read_value_o = out_val_q;

endmodule
`default_nettype wire

// File: rtl/core/lkv_cell.sv
// One cache entry: key, value, valid and recency rank, chained to its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module lkv_cell #(
  parameter int unsigned RKW = 5
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  match_en_i,
  input  wire                  apply_en_i,
  input  lkv_pkg::cmd_t        cmd_i,
  input  wire  [RKW-1:0]       old_rank_i,
  input  wire  [RKW-1:0]       cap_i,
  input  lkv_pkg::chain_t      chain_i,
  output lkv_pkg::chain_t      chain_o,
  input  wire  [RKW-1:0]       rank_chain_i,
  output logic [RKW-1:0]       rank_chain_o
);
  import lkv_pkg::*;

  logic              valid_q, valid_d;
  logic              match_q, match_d;
  logic [RKW-1:0]    rank_q, rank_d;
  logic [DATA_W-1:0] key_q, value_q;
  logic [RKW-1:0]    rank_inc, rank_n;
  logic              keep, take, upd, wr_value;

  assign rank_inc = rank_q + RKW'(1);

  always_comb begin
    if (cmd_i.hit) begin
      if (match_q) begin
        rank_n = '0;
      end else if (valid_q && (rank_q < old_rank_i)) begin
        rank_n = rank_inc;
      end else begin
        rank_n = rank_q;
      end
    end else begin
      rank_n = valid_q ? rank_inc : rank_q;
    end
  end

  assign keep     = valid_q && (rank_n < cap_i);
  assign take     = cmd_i.put && !cmd_i.hit && !keep && chain_i.first_free && (cap_i != '0);
  assign upd      = apply_en_i && (cmd_i.put || cmd_i.hit);
  assign wr_value = take || (cmd_i.put && cmd_i.hit && match_q);

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    match_d = match_q;
    if (match_en_i) begin
      match_d = valid_q && (key_q == cmd_i.key);
    end
    if (upd) begin
      valid_d = take || (cmd_i.put ? keep : valid_q);
      rank_d  = take ? '0 : rank_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd && take) begin
      key_q <= cmd_i.key;
    end
    if (upd && wr_value) begin
      value_q <= cmd_i.value;
    end
  end

  assign chain_o.hit        = chain_i.hit | match_q;
  assign chain_o.first_free = chain_i.first_free & keep;
  assign chain_o.value      = chain_i.value | (match_q ? value_q : '0);
  assign rank_chain_o       = rank_chain_i | (match_q ? rank_q : '0);

endmodule
`default_nettype wire

// File: rtl/core/lkv_checker.sv
// Port-level checks for the LRU key/value cache, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lkv_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_o,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire        hit_o,
  input wire [31:0] read_value_o
);

  // Stalled response holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) && $stable(read_value_o))
    else $error("response changed while stalled");

  // Miss returns all ones.
  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> read_value_o == 32'hFFFF_FFFF)
    else $error("miss response not all ones");

  // One request in flight.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a request");

  // A response is produced only while a request is being worked on.
  a_resp_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("response without a request in flight");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .hit_o       (hit_o),
  .read_value_o(read_value_o)
);
`default_nettype wire
